FILE: rtl/hmt_pkg.sv
// Package: shared types and constants of the heartbeat membership table.
`default_nettype none
package hmt_pkg;

   localparam int unsigned DefaultMaxMembers = 16;
   localparam int unsigned MaxResults = 32;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_JOIN_REQ = 2'd1,
      OP_JOIN_REP = 2'd2,
      OP_HEARTBT  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_DONE     = 3'd0,
      KIND_HB_SEND  = 3'd1,
      KIND_JOIN_REP = 3'd2,
      KIND_ADDED    = 3'd3,
      KIND_REMOVED  = 3'd4,
      KIND_FULL     = 3'd5
   } kind_type;

   // register indexes
   localparam logic [2:0] REG_SELF_ID   = 3'd0;
   localparam logic [2:0] REG_SELF_PORT = 3'd1;
   localparam logic [2:0] REG_PING      = 3'd2;
   localparam logic [2:0] REG_TIMEOUT   = 3'd3;
   localparam logic [2:0] REG_FAILED    = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_SCAN,
      ST_ADD_EMIT,
      ST_SEND_SCAN,
      ST_AGE_SCAN,
      ST_REP_SCAN,
      ST_HB_SCAN,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       latch_in;     // capture the transaction
      logic       clr_idx;      // restart slot walk
      logic       inc_idx;      // advance slot walk
      logic       write_slot;   // write new member at free slot
      logic       emit_add;     // emit added or full
      logic       emit_send;    // emit heartbeat send for walked slot
      logic       emit_rem;     // emit removed and drop slot
      logic       emit_rep;     // emit join reply entry for walked slot
      logic       emit_done;    // release held result as last, or a done result
      logic       hb_update;    // update walked slot heartbeat
      logic       tick_start;   // bump heartbeat or count down
      logic       tick_end;     // advance local time
      logic       set_joined;   // mark joined
      logic       add_local;    // new member stamp is local time
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic       idx_end;      // walked index is the last slot
      logic       slot_valid;   // walked slot valid
      logic       slot_self;    // walked slot is own address
      logic       slot_old;     // walked slot older than timeout
      logic       slot_idmatch; // walked slot id equals transaction id
      logic       cd_zero;      // countdown is zero
      logic       tick_enable;  // joined or introducer
      logic       failed;       // node failed
      logic       cnt_full;     // result limit reached
      opcode_type op;
   } sts_type;

endpackage
`default_nettype wire

FILE: rtl/hmt_datapath.sv
// Datapath: member table, counters, configuration registers and result register.
`default_nettype none
module hmt_datapath #(
   parameter int unsigned MAX_MEMBERS = hmt_pkg::DefaultMaxMembers
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hmt_pkg::ctl_type    ctl,
   output hmt_pkg::sts_type         sts,
   input  wire logic [1:0]          req_opcode,
   input  wire logic [31:0]         req_node_id,
   input  wire logic [15:0]         req_node_port,
   input  wire logic [31:0]         req_heartbeat_value,
   input  wire logic signed [31:0]  req_entry_timestamp,
   input  wire logic                cfg_we,
   input  wire logic [2:0]          cfg_idx,
   input  wire logic [31:0]         cfg_data,
   output logic [31:0]              cfg_rdata,
   output logic                     rsp_valid,
   output logic [2:0]               rsp_result_kind,
   output logic [31:0]              rsp_dest_id,
   output logic [15:0]              rsp_dest_port,
   output logic [31:0]              rsp_entry_id,
   output logic [15:0]              rsp_entry_port,
   output logic [31:0]              rsp_entry_heartbeat,
   output logic signed [31:0]       rsp_entry_time,
   output logic                     rsp_last
);
   import hmt_pkg::*;

   localparam int unsigned IdxW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
   localparam int unsigned CntW = $clog2(MaxResults + 1);

   // configuration
   logic [31:0] self_id_ff;
   logic [15:0] self_port_ff, ping_period_ff, timeout_ff;
   logic        failed_ff;

   // scalar state
   logic [31:0] local_time_ff, own_hb_ff;
   logic [15:0] countdown_ff;
   logic        joined_ff;

   // table: valid bits in flops, payload in memories
   logic [MAX_MEMBERS-1:0] valid_ff;
   logic [31:0] mem_id   [MAX_MEMBERS];
   logic [15:0] mem_port [MAX_MEMBERS];
   logic [31:0] mem_hb   [MAX_MEMBERS];
   logic [31:0] mem_ts   [MAX_MEMBERS];

   // captured transaction
   opcode_type  op_ff;
   logic [31:0] id_ff, hb_ff, ts_ff;
   logic [15:0] port_ff;

   logic [IdxW-1:0] idx_ff;
   logic [CntW-1:0] cnt_ff;
   logic [IdxW-1:0] free_idx;
   logic            free_found;

   // staged result, released when the next one is produced or the item closes
   kind_type    stg_kind_ff;
   logic [31:0] stg_did_ff, stg_eid_ff, stg_ehb_ff, stg_etime_ff;
   logic [15:0] stg_dport_ff, stg_eport_ff;
   logic        stg_valid_ff;
   logic        emit_any;

   // read of walked slot
   logic [31:0] rd_id, rd_hb, rd_ts;
   logic [15:0] rd_port;

   assign rd_id   = mem_id[idx_ff];
   assign rd_port = mem_port[idx_ff];
   assign rd_hb   = mem_hb[idx_ff];
   assign rd_ts   = mem_ts[idx_ff];

   assign emit_any = (ctl.emit_add || ctl.emit_send || ctl.emit_rem || ctl.emit_rep) &&
                     !sts.cnt_full;

   // lowest free slot
   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      for (int i = MAX_MEMBERS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx   = IdxW'(i);
            free_found = 1'b1;
         end
      end
   end

   logic signed [32:0] age;
   assign age = $signed({local_time_ff[31], local_time_ff}) - $signed({rd_ts[31], rd_ts});

   always_comb begin
      sts.idx_end      = (idx_ff == IdxW'(MAX_MEMBERS - 1));
      sts.slot_valid   = valid_ff[idx_ff];
      sts.slot_self    = (rd_id == self_id_ff) && (rd_port == self_port_ff);
      sts.slot_old     = age > $signed({17'd0, timeout_ff});
      sts.slot_idmatch = (rd_id == id_ff);
      sts.cd_zero      = (countdown_ff == '0);
      sts.tick_enable  = joined_ff || ((self_id_ff == 32'd1) && (self_port_ff == 16'd0));
      sts.failed       = failed_ff;
      sts.cnt_full     = (cnt_ff == CntW'(MaxResults));
      sts.op           = op_ff;
   end

   always_comb begin
      unique case (cfg_idx)
         REG_SELF_ID:   cfg_rdata = self_id_ff;
         REG_SELF_PORT: cfg_rdata = {16'd0, self_port_ff};
         REG_PING:      cfg_rdata = {16'd0, ping_period_ff};
         REG_TIMEOUT:   cfg_rdata = {16'd0, timeout_ff};
         REG_FAILED:    cfg_rdata = {31'd0, failed_ff};
         default:       cfg_rdata = '0;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         self_id_ff     <= 32'd1;
         self_port_ff   <= '0;
         ping_period_ff <= 16'd5;
         timeout_ff     <= 16'd20;
         failed_ff      <= 1'b0;
         local_time_ff  <= '1;
         own_hb_ff      <= '0;
         countdown_ff   <= 16'd5;
         joined_ff      <= 1'b0;
         valid_ff       <= '0;
         rsp_valid      <= 1'b0;
         stg_valid_ff   <= 1'b0;
         cnt_ff         <= '0;
         idx_ff         <= '0;
      end else begin
         rsp_valid <= 1'b0;
         if (cfg_we) begin
            unique case (cfg_idx)
               REG_SELF_ID:   self_id_ff <= cfg_data;
               REG_SELF_PORT: self_port_ff <= cfg_data[15:0];
               REG_PING: begin
                  ping_period_ff <= cfg_data[15:0];
                  countdown_ff   <= cfg_data[15:0];
               end
               REG_TIMEOUT:   timeout_ff <= cfg_data[15:0];
               REG_FAILED:    failed_ff <= cfg_data[0];
               default: ;
            endcase
         end
         if (ctl.latch_in) cnt_ff <= '0;
         if (ctl.clr_idx) idx_ff <= '0;
         else if (ctl.inc_idx) idx_ff <= idx_ff + 1'b1;
         if (ctl.write_slot && free_found) valid_ff[free_idx] <= 1'b1;
         if (ctl.emit_rem) valid_ff[idx_ff] <= 1'b0;
         if (ctl.set_joined) joined_ff <= 1'b1;
         if (ctl.tick_start) begin
            if (countdown_ff == '0) begin
               own_hb_ff    <= own_hb_ff + 1'b1;
               countdown_ff <= ping_period_ff;
            end else begin
               countdown_ff <= countdown_ff - 1'b1;
            end
         end
         if (ctl.tick_end) local_time_ff <= local_time_ff + 1'b1;
         // stage a new result and push out the held one
         if (emit_any) begin
            stg_valid_ff <= 1'b1;
            rsp_valid    <= stg_valid_ff;
            cnt_ff       <= cnt_ff + 1'b1;
         end else if (ctl.emit_done) begin
            stg_valid_ff <= 1'b0;
            rsp_valid    <= 1'b1;
         end
      end
   end

   // payload: transaction capture, table memories, result fields
   always_ff @(posedge clock) begin
      if (ctl.latch_in) begin
         op_ff   <= opcode_type'(req_opcode);
         id_ff   <= req_node_id;
         port_ff <= req_node_port;
         hb_ff   <= req_heartbeat_value;
         ts_ff   <= req_entry_timestamp;
      end
      if (ctl.write_slot && free_found) begin
         mem_id[free_idx]   <= id_ff;
         mem_port[free_idx] <= port_ff;
         mem_hb[free_idx]   <= hb_ff;
         mem_ts[free_idx]   <= ctl.add_local ? local_time_ff : ts_ff;
      end
      if (ctl.hb_update) begin
         mem_hb[idx_ff] <= hb_ff;
         mem_ts[idx_ff] <= local_time_ff;
      end
      if (emit_any) begin
         // held result leaves, not last since another follows
         rsp_result_kind     <= stg_kind_ff;
         rsp_dest_id         <= stg_did_ff;
         rsp_dest_port       <= stg_dport_ff;
         rsp_entry_id        <= stg_eid_ff;
         rsp_entry_port      <= stg_eport_ff;
         rsp_entry_heartbeat <= stg_ehb_ff;
         rsp_entry_time      <= stg_etime_ff;
         rsp_last            <= 1'b0;
         if (ctl.emit_add) begin
            stg_kind_ff  <= free_found ? KIND_ADDED : KIND_FULL;
            stg_did_ff   <= id_ff;
            stg_dport_ff <= port_ff;
            stg_eid_ff   <= '0;
            stg_eport_ff <= '0;
            stg_ehb_ff   <= '0;
            stg_etime_ff <= '0;
         end else if (ctl.emit_send) begin
            stg_kind_ff  <= KIND_HB_SEND;
            stg_did_ff   <= rd_id;
            stg_dport_ff <= rd_port;
            stg_eid_ff   <= self_id_ff;
            stg_eport_ff <= self_port_ff;
            stg_ehb_ff   <= own_hb_ff;
            stg_etime_ff <= '0;
         end else if (ctl.emit_rem) begin
            stg_kind_ff  <= KIND_REMOVED;
            stg_did_ff   <= rd_id;
            stg_dport_ff <= rd_port;
            stg_eid_ff   <= '0;
            stg_eport_ff <= '0;
            stg_ehb_ff   <= '0;
            stg_etime_ff <= '0;
         end else begin
            stg_kind_ff  <= KIND_JOIN_REP;
            stg_did_ff   <= id_ff;
            stg_dport_ff <= port_ff;
            stg_eid_ff   <= rd_id;
            stg_eport_ff <= rd_port;
            stg_ehb_ff   <= rd_hb;
            stg_etime_ff <= rd_ts;
         end
      end else if (ctl.emit_done) begin
         // close the item with the held result, or a done result
         rsp_last <= 1'b1;
         if (stg_valid_ff) begin
            rsp_result_kind     <= stg_kind_ff;
            rsp_dest_id         <= stg_did_ff;
            rsp_dest_port       <= stg_dport_ff;
            rsp_entry_id        <= stg_eid_ff;
            rsp_entry_port      <= stg_eport_ff;
            rsp_entry_heartbeat <= stg_ehb_ff;
            rsp_entry_time      <= stg_etime_ff;
         end else begin
            rsp_result_kind     <= KIND_DONE;
            rsp_dest_id         <= '0;
            rsp_dest_port       <= '0;
            rsp_entry_id        <= '0;
            rsp_entry_port      <= '0;
            rsp_entry_heartbeat <= '0;
            rsp_entry_time      <= '0;
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/hmt_ctrl.sv
// Controller: sequences one transaction over the slot walks.
`default_nettype none
module hmt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire hmt_pkg::sts_type sts,
   output hmt_pkg::ctl_type      ctl
);
   import hmt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Every transaction closes through the done step, which marks the final result.
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.latch_in = 1'b1;
               ctl.clr_idx  = 1'b1;
               state_in     = ST_ADD_SCAN;
            end
         end
         // dispatch on opcode
         ST_ADD_SCAN: begin
            ctl.clr_idx = 1'b1;
            if (sts.failed) begin
               state_in = ST_DONE;
            end else begin
               unique case (sts.op)
                  OP_TICK: begin
                     if (!sts.tick_enable) state_in = ST_DONE;
                     else begin
                        ctl.tick_start = 1'b1;
                        state_in = sts.cd_zero ? ST_SEND_SCAN : ST_AGE_SCAN;
                     end
                  end
                  OP_JOIN_REQ, OP_JOIN_REP: state_in = ST_ADD_EMIT;
                  OP_HEARTBT:               state_in = ST_HB_SCAN;
                  default:                  state_in = ST_DONE;
               endcase
            end
         end
         // add member and report
         ST_ADD_EMIT: begin
            ctl.write_slot = 1'b1;
            ctl.emit_add   = 1'b1;
            ctl.add_local  = (sts.op != OP_JOIN_REP);
            ctl.set_joined = (sts.op == OP_JOIN_REP);
            if (sts.op == OP_JOIN_REQ) state_in = ST_REP_SCAN;
            else                       state_in = ST_DONE;
         end
         // heartbeat sends over all non-self members
         ST_SEND_SCAN: begin
            ctl.inc_idx   = 1'b1;
            ctl.emit_send = sts.slot_valid && !sts.slot_self;
            if (sts.idx_end) begin
               ctl.clr_idx = 1'b1;
               state_in    = ST_AGE_SCAN;
            end
         end
         // drop stale members, advance local time on the final slot
         ST_AGE_SCAN: begin
            ctl.inc_idx  = 1'b1;
            ctl.emit_rem = sts.slot_valid && !sts.slot_self && sts.slot_old;
            if (sts.idx_end) begin
               ctl.tick_end = 1'b1;
               state_in     = ST_DONE;
            end
         end
         // join reply entries for all valid slots
         ST_REP_SCAN: begin
            ctl.inc_idx  = 1'b1;
            ctl.emit_rep = sts.slot_valid;
            if (sts.idx_end) state_in = ST_DONE;
         end
         // update first matching id, else add
         ST_HB_SCAN: begin
            ctl.inc_idx = 1'b1;
            if (sts.slot_valid && sts.slot_idmatch) begin
               ctl.hb_update = 1'b1;
               state_in      = ST_DONE;
            end else if (sts.idx_end) begin
               state_in = ST_ADD_EMIT;
            end
         end
         // close the item: release the held result as last, or a done result
         ST_DONE: begin
            ctl.emit_done = 1'b1;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/heartbeat_membership_table_core.sv
// Top level: heartbeat membership table with command port and APB-style registers.
//
// Usage: raise start with the req_ fields while busy is low; the transaction is
// taken at that edge and busy stays high while the table is walked. Results
// appear on the rsp_ ports for one cycle each, marked by rsp_valid; rsp_last
// flags the final result of a transaction. The receiver cannot stall.
// Each result is held in a staging register until the next one is produced,
// so the final result leaves in the same cycle that busy falls, and the next
// transaction can be taken at the end of that cycle.
// A tick with sends walks the table twice; a tick without sends walks it once;
// a join request walks it once; a heartbeat message walks up to the whole
// table; a join reply entry, a failed node or an idle tick walks none. The walk
// visits one slot per cycle over the table memories. Configuration registers
// sit at byte addresses 4*i and are to be written by the user only while busy
// is low; the block itself does not enforce this. Reset empties the table, sets
// local time to minus one, clears the own heartbeat and joined flag and reloads
// register defaults.
`default_nettype none
module heartbeat_membership_table_core #(
   parameter int unsigned MAX_MEMBERS = hmt_pkg::DefaultMaxMembers
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [31:0]        req_node_id,
   input  wire logic [15:0]        req_node_port,
   input  wire logic [31:0]        req_heartbeat_value,
   input  wire logic signed [31:0] req_entry_timestamp,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_result_kind,
   output logic [31:0]             rsp_dest_id,
   output logic [15:0]             rsp_dest_port,
   output logic [31:0]             rsp_entry_id,
   output logic [15:0]             rsp_entry_port,
   output logic [31:0]             rsp_entry_heartbeat,
   output logic signed [31:0]      rsp_entry_time,
   output logic                    rsp_last,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [4:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import hmt_pkg::*;

   ctl_type ctl;
   sts_type sts;
   logic    cfg_we;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite;

   hmt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   hmt_datapath #(.MAX_MEMBERS(MAX_MEMBERS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .sts                 (sts),
      .req_opcode          (req_opcode),
      .req_node_id         (req_node_id),
      .req_node_port       (req_node_port),
      .req_heartbeat_value (req_heartbeat_value),
      .req_entry_timestamp (req_entry_timestamp),
      .cfg_we              (cfg_we),
      .cfg_idx             (paddr[4:2]),
      .cfg_data            (pwdata),
      .cfg_rdata           (prdata),
      .rsp_valid           (rsp_valid),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_dest_id         (rsp_dest_id),
      .rsp_dest_port       (rsp_dest_port),
      .rsp_entry_id        (rsp_entry_id),
      .rsp_entry_port      (rsp_entry_port),
      .rsp_entry_heartbeat (rsp_entry_heartbeat),
      .rsp_entry_time      (rsp_entry_time),
      .rsp_last            (rsp_last)
   );

   // a start taken while busy is low raises busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");
   // a result marked last ends the transaction
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy) else $error("last while busy");
   // every strobed result carries a defined kind
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_kind <= KIND_FULL)) else $error("bad result kind");

endmodule
`default_nettype wire
